// ----- design/tpct_pkg.sv -----
// shared widths, mode codes and helper functions for the triangle pixel coverage test
package tpct_pkg;

	localparam int CoordW  = 16;                 // 12.4 vertex coordinate
	localparam int DiffW   = CoordW + 1;         // signed coordinate difference
	localparam int WeightW = 2 * DiffW;          // product of two differences
	localparam int PixW    = 12;                 // pixel row or column
	localparam int FracW   = 4;                  // sub-pixel bits
	localparam int BoxW    = CoordW + 1;         // box edges, room for round-up
	localparam int CfgW    = 10;                 // widest register
	localparam int CfgIdxW = 3;
	localparam int ModeW   = 2;

	localparam logic [FracW-1:0] SampleOfs = FracW'(8);
	localparam logic [BoxW-1:0]  RoundUp   = BoxW'(15);

	typedef enum logic [ModeW-1:0] {
		CULL_KEEP_ALL = 2'd0,
		CULL_KEEP_CW  = 2'd1,
		CULL_KEEP_CCW = 2'd2
	} cull_mode_t;

	typedef enum logic [ModeW-1:0] {
		SCIS_OFF     = 2'd0,
		SCIS_INCLUDE = 2'd1,
		SCIS_EXCLUDE = 2'd2
	} scissor_mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CULL_MODE      = 3'd0,
		REG_SCISSOR_MODE   = 3'd1,
		REG_SCISSOR_LEFT   = 3'd2,
		REG_SCISSOR_TOP    = 3'd3,
		REG_SCISSOR_RIGHT  = 3'd4,
		REG_SCISSOR_BOTTOM = 3'd5
	} cfg_reg_t;

	// a - b on unsigned coordinates, exact
	function automatic logic signed [DiffW-1:0] cdiff(input logic [CoordW-1:0] a,
			input logic [CoordW-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic [CoordW-1:0] min3(input logic [CoordW-1:0] a,
			input logic [CoordW-1:0] b, input logic [CoordW-1:0] c);
		logic [CoordW-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic [CoordW-1:0] max3(input logic [CoordW-1:0] a,
			input logic [CoordW-1:0] b, input logic [CoordW-1:0] c);
		logic [CoordW-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

// ----- design/triangle_pixel_coverage_test_core.sv -----
// triangle pixel coverage test: winding cull, box and scissor test, biased edge weights
//
// usage
//   input: an item transfers at a rising edge with start high and busy low. busy is
//   always low: the pipeline takes a new item every cycle, so the sustained rate is
//   one item per clock.
//   output: done is high for exactly one cycle with covered, culled, weight0..2 and
//   swapped; the receiver takes the transfer at the edge that ends that cycle and
//   cannot hold it off, which this block never needs since nothing stalls.
//   order: results come out in the order items went in.
//   pipeline: s1 main-area products, s2 area sign, cull and vertex swap, box min/max
//   and include clip, s3 edge and fill-rule products plus box round and compare,
//   s4 product differences and sign normalization, s5 fill-rule bias and weights.
//   the 17x17 multiplies sit in s1 and s3, each with a register after it.
//   config: cfg_write with cfg_index and cfg_data writes one register at an edge;
//   only write while no item is in flight (five cycles after the last start).
//   reset: arst_n low clears all valid bits and loads the register defaults
//   (keep all, scissor off, box 0..1023 in both axes).
module triangle_pixel_coverage_test_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tpct_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [tpct_pkg::CfgW-1:0]           cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [tpct_pkg::CoordW-1:0]         vert0_x,
	input  logic [tpct_pkg::CoordW-1:0]         vert0_y,
	input  logic [tpct_pkg::CoordW-1:0]         vert1_x,
	input  logic [tpct_pkg::CoordW-1:0]         vert1_y,
	input  logic [tpct_pkg::CoordW-1:0]         vert2_x,
	input  logic [tpct_pkg::CoordW-1:0]         vert2_y,
	input  logic [tpct_pkg::PixW-1:0]           pixel_col,
	input  logic [tpct_pkg::PixW-1:0]           pixel_row,
	output logic                                done,
	output logic                                covered,
	output logic                                culled,
	output logic signed [tpct_pkg::WeightW-1:0] weight0,
	output logic signed [tpct_pkg::WeightW-1:0] weight1,
	output logic signed [tpct_pkg::WeightW-1:0] weight2,
	output logic                                swapped
);
	import tpct_pkg::*;

	// ---------------------------------------------------------------- config
	cull_mode_t     cull_mode_q;
	scissor_mode_t  scissor_mode_q;
	logic [CfgW-1:0] scis_left_q, scis_top_q, scis_right_q, scis_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_mode_q    <= CULL_KEEP_ALL;
			scissor_mode_q <= SCIS_OFF;
			scis_left_q    <= '0;
			scis_top_q     <= '0;
			scis_right_q   <= '1;
			scis_bottom_q  <= '1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CULL_MODE:      cull_mode_q    <= cull_mode_t'(cfg_data[ModeW-1:0]);
				REG_SCISSOR_MODE:   scissor_mode_q <= scissor_mode_t'(cfg_data[ModeW-1:0]);
				REG_SCISSOR_LEFT:   scis_left_q    <= cfg_data;
				REG_SCISSOR_TOP:    scis_top_q     <= cfg_data;
				REG_SCISSOR_RIGHT:  scis_right_q   <= cfg_data;
				REG_SCISSOR_BOTTOM: scis_bottom_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// scissor box edges in sub-pixel units; right and bottom are exclusive
	logic [BoxW-1:0] scis_l, scis_t, scis_r, scis_b;
	assign scis_l = BoxW'({scis_left_q, {FracW{1'b0}}});
	assign scis_t = BoxW'({scis_top_q, {FracW{1'b0}}});
	assign scis_r = BoxW'({({1'b0, scis_right_q} + (CfgW + 1)'(1)), {FracW{1'b0}}});
	assign scis_b = BoxW'({({1'b0, scis_bottom_q} + (CfgW + 1)'(1)), {FracW{1'b0}}});

	// fully pipelined, never refuses a transfer
	assign busy = 1'b0;

	// ---------------------------------------------------------------- stage 1
	// products of the whole-triangle signed area
	logic [CoordW-1:0] vx_in [3];
	logic [CoordW-1:0] vy_in [3];
	assign vx_in[0] = vert0_x;
	assign vx_in[1] = vert1_x;
	assign vx_in[2] = vert2_x;
	assign vy_in[0] = vert0_y;
	assign vy_in[1] = vert1_y;
	assign vy_in[2] = vert2_y;

	logic                      v_s1;
	logic [CoordW-1:0]         vx_s1 [3];
	logic [CoordW-1:0]         vy_s1 [3];
	logic [CoordW-1:0]         px_s1, py_s1;
	logic signed [WeightW-1:0] pa_s1, pb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vx_s1 <= vx_in;
			vy_s1 <= vy_in;
			px_s1 <= {pixel_col, SampleOfs};
			py_s1 <= {pixel_row, SampleOfs};
			pa_s1 <= cdiff(vert1_x, vert0_x) * cdiff(vert2_y, vert0_y);
			pb_s1 <= cdiff(vert1_y, vert0_y) * cdiff(vert2_x, vert0_x);
		end
	end

	// ---------------------------------------------------------------- stage 2
	// winding decision, vertex swap, box min/max with include clip
	logic signed [WeightW-1:0] area_tri;
	logic                      swap_nx, cull_nx;
	logic [BoxW-1:0]           minx_nx, miny_nx, maxx_nx, maxy_nx;

	assign area_tri = pa_s1 - pb_s1;

	always_comb begin
		swap_nx = 1'b0;
		cull_nx = 1'b0;
		case (cull_mode_q)
			CULL_KEEP_ALL: swap_nx = (area_tri <= 0);
			CULL_KEEP_CW: begin
				swap_nx = 1'b1;
				cull_nx = (area_tri >= 0);
			end
			// keep ccw, and the unused code behaves the same
			default: cull_nx = (area_tri <= 0);
		endcase
	end

	always_comb begin
		// box is the same whichever way the vertices are ordered
		minx_nx = BoxW'(min3(vx_s1[0], vx_s1[1], vx_s1[2]));
		miny_nx = BoxW'(min3(vy_s1[0], vy_s1[1], vy_s1[2]));
		maxx_nx = BoxW'(max3(vx_s1[0], vx_s1[1], vx_s1[2]));
		maxy_nx = BoxW'(max3(vy_s1[0], vy_s1[1], vy_s1[2]));
		if (scissor_mode_q == SCIS_INCLUDE) begin
			if (minx_nx < scis_l) minx_nx = scis_l;
			if (miny_nx < scis_t) miny_nx = scis_t;
			if (maxx_nx > scis_r) maxx_nx = scis_r;
			if (maxy_nx > scis_b) maxy_nx = scis_b;
		end
	end

	logic              v_s2, swap_s2, cull_s2;
	logic [CoordW-1:0] vx_s2 [3];
	logic [CoordW-1:0] vy_s2 [3];
	logic [CoordW-1:0] px_s2, py_s2;
	logic [BoxW-1:0]   minx_s2, miny_s2, maxx_s2, maxy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			swap_s2  <= swap_nx;
			cull_s2  <= cull_nx;
			vx_s2[0] <= vx_s1[0];
			vy_s2[0] <= vy_s1[0];
			vx_s2[1] <= swap_nx ? vx_s1[2] : vx_s1[1];
			vy_s2[1] <= swap_nx ? vy_s1[2] : vy_s1[1];
			vx_s2[2] <= swap_nx ? vx_s1[1] : vx_s1[2];
			vy_s2[2] <= swap_nx ? vy_s1[1] : vy_s1[2];
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			minx_s2  <= minx_nx;
			miny_s2  <= miny_nx;
			maxx_s2  <= maxx_nx;
			maxy_s2  <= maxy_nx;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// box rounded to whole pixels, sample tests; per-edge products below
	logic [BoxW-1:0] minx_r, miny_r, maxx_r, maxy_r, sx, sy;
	logic            in_box, excluded;

	assign minx_r = {minx_s2[BoxW-1:FracW], {FracW{1'b0}}};
	assign miny_r = {miny_s2[BoxW-1:FracW], {FracW{1'b0}}};
	assign maxx_r = (maxx_s2 + RoundUp) & ~RoundUp;
	assign maxy_r = (maxy_s2 + RoundUp) & ~RoundUp;
	assign sx     = BoxW'(px_s2);
	assign sy     = BoxW'(py_s2);
	assign in_box = (sx >= (minx_r | BoxW'(SampleOfs))) && (sx < maxx_r)
		&& (sy >= (miny_r | BoxW'(SampleOfs))) && (sy < maxy_r);
	assign excluded = (scissor_mode_q == SCIS_EXCLUDE) && (sx >= scis_l) && (sx < scis_r)
		&& (sy >= scis_t) && (sy < scis_b);

	logic v_s3, swap_s3, cull_s3, inside_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			swap_s3   <= swap_s2;
			cull_s3   <= cull_s2;
			inside_s3 <= in_box && !excluded;
		end
	end

	logic v_s4, swap_s4, cull_s4, inside_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			swap_s4   <= swap_s3;
			cull_s4   <= cull_s3;
			inside_s4 <= inside_s3;
		end
	end

	// ---------------------------------------------------------------- edges
	// edge k runs from vertex k+1 to vertex k+2 and faces vertex k.
	// fill rule: bias -1 when the vertex lies left of the edge at its own row,
	// with the edge x truncated toward zero. with q = num/den, d = vx - l1x:
	//   q >= 0: d < trunc(q)  <=>  (d+1)*|den| <= num'
	//   q <  0: d < trunc(q)  <=>  d*|den| < num'
	// where num' carries the sign of den, so no divider is needed
	logic signed [WeightW-1:0] wgt_nx [3];
	logic                      wneg_nx [3];

	for (genvar k = 0; k < 3; k++) begin : g_edge
		localparam int L1 = (k + 1) % 3;
		localparam int L2 = (k + 2) % 3;

		logic signed [DiffW-1:0]   ex, ey, qx, qy, dvx, dvy;
		logic signed [WeightW-1:0] area_a_s3, area_b_s3, num_s3, prod_s3;
		logic signed [DiffW-1:0]   den_s3;
		logic                      above_s3;

		assign ex  = cdiff(vx_s2[L2], vx_s2[L1]);
		assign ey  = cdiff(vy_s2[L2], vy_s2[L1]);
		assign qx  = cdiff(px_s2, vx_s2[L1]);
		assign qy  = cdiff(py_s2, vy_s2[L1]);
		assign dvx = cdiff(vx_s2[k], vx_s2[L1]);
		assign dvy = cdiff(vy_s2[k], vy_s2[L1]);

		always_ff @(posedge clk) begin
			if (v_s2) begin
				area_a_s3 <= ex * qy;
				area_b_s3 <= ey * qx;
				num_s3    <= ex * dvy;
				prod_s3   <= dvx * ey;
				den_s3    <= ey;
				above_s3  <= vy_s2[k] < vy_s2[L1];
			end
		end

		// stage 4: area difference, sign normalization by den
		logic                      neg;
		logic signed [DiffW-1:0]   den_abs;
		logic signed [WeightW-1:0] prod_n;
		logic signed [WeightW-1:0] area_s4, num_s4, prod_s4, prodd_s4;
		logic                      flat_s4, above_s4;

		assign neg     = den_s3[DiffW-1];
		assign den_abs = neg ? -den_s3 : den_s3;
		assign prod_n  = neg ? -prod_s3 : prod_s3;

		always_ff @(posedge clk) begin
			if (v_s3) begin
				area_s4  <= area_a_s3 - area_b_s3;
				num_s4   <= neg ? -num_s3 : num_s3;
				prod_s4  <= prod_n;
				prodd_s4 <= prod_n + WeightW'(den_abs);
				flat_s4  <= (den_s3 == '0);
				above_s4 <= above_s3;
			end
		end

		// stage 5 inputs: bias and weight
		logic right;
		always_comb begin
			if (flat_s4) begin
				right = above_s4;
			end else if (num_s4[WeightW-1]) begin
				right = prod_s4 < num_s4;
			end else begin
				right = prodd_s4 <= num_s4;
			end
		end

		assign wgt_nx[k]  = right ? (area_s4 - WeightW'(1)) : area_s4;
		assign wneg_nx[k] = right ? (area_s4 <= 0) : area_s4[WeightW-1];
	end

	// ---------------------------------------------------------------- stage 5
	logic                      v_s5, cov_s5, cull_s5, swap_s5;
	logic signed [WeightW-1:0] w0_s5, w1_s5, w2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			cull_s5 <= cull_s4;
			swap_s5 <= swap_s4;
			cov_s5  <= !cull_s4 && inside_s4 && !wneg_nx[0] && !wneg_nx[1] && !wneg_nx[2];
			// a culled triangle reports zero weights
			w0_s5   <= cull_s4 ? '0 : wgt_nx[0];
			w1_s5   <= cull_s4 ? '0 : wgt_nx[1];
			w2_s5   <= cull_s4 ? '0 : wgt_nx[2];
		end
	end

	assign done    = v_s5;
	assign covered = cov_s5;
	assign culled  = cull_s5;
	assign swapped = swap_s5;
	assign weight0 = w0_s5;
	assign weight1 = w1_s5;
	assign weight2 = w2_s5;

	// ---------------------------------------------------------------- checks
	// every transfer in gives exactly one result, and no result comes without one
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("accepted item produced no result after five cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without a matching accepted item");

	// a covered pixel has all three biased weights non-negative
	a_cov_weights: assert property (@(posedge clk) disable iff (!arst_n)
		(done && covered) |-> (!weight0[WeightW-1] && !weight1[WeightW-1]
			&& !weight2[WeightW-1] && !culled))
		else $error("covered pixel with a negative weight or culled triangle");

endmodule

// ----- bench/triangle_pixel_coverage_test_core_test.sv -----
// self-checking bench for the triangle pixel coverage test core
module triangle_pixel_coverage_test_core_test;
	import tpct_pkg::*;

	// watchdog: cycles in a row with no transfer on either side
	localparam int StallLimit = 1000;
	// pipeline latency plus margin
	localparam int DrainCycles = 8;
	// chance in a hundred that the sender stays idle at each edge ahead of a transfer
	localparam int IdlePct = 28;
	localparam longint CoordMax = 2 ** CoordW - 1;
	localparam longint PixMax = 2 ** PixW - 1;
	localparam logic [CfgW-1:0] ScisLast = '1;
	// mode code three has no name in the package: cull acts as keep ccw, scissor as off
	localparam logic [ModeW-1:0] CULL_MODE_THREE = 2'd3;
	localparam logic [ModeW-1:0] SCIS_MODE_THREE = 2'd3;

	// one triangle and one pixel
	typedef struct {
		logic [CoordW-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
		logic [PixW-1:0] col, row;
	} tri_item_t;

	// one coverage result
	typedef struct {
		logic covered;
		logic culled;
		logic signed [WeightW-1:0] w0, w1, w2;
		logic swapped;
	} coverage_t;

	// predicts coverage from its own copy of the registers and keeps the results in flight
	class coverage_scoreboard;
		logic [ModeW-1:0] cull, scis;
		logic [CfgW-1:0] left, top, right, bottom;
		coverage_t pending_q[$];
		int errors, checked, noted, n_covered, n_culled, n_swapped;

		function new();
			cull = CULL_KEEP_ALL;
			scis = SCIS_OFF;
			left = '0;
			top = '0;
			right = ScisLast;
			bottom = ScisLast;
		endfunction

		function void set_register(input cfg_reg_t idx, input logic [CfgW-1:0] val);
			case (idx)
				REG_CULL_MODE: cull = val[ModeW-1:0];
				REG_SCISSOR_MODE: scis = val[ModeW-1:0];
				REG_SCISSOR_LEFT: left = val;
				REG_SCISSOR_TOP: top = val;
				REG_SCISSOR_RIGHT: right = val;
				REG_SCISSOR_BOTTOM: bottom = val;
				default: ;
			endcase
		endfunction

		function longint signed_area(input longint ax, ay, bx, by, cx, cy);
			return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		endfunction

		// top-left style bias: -1 for a flat edge below the vertex or an edge to its right
		function longint fill_bias(input longint vx, vy, ax, ay, bx, by);
			longint t;
			if (ay == by)
				return (vy < ay) ? -1 : 0;
			t = ((bx - ax) * (vy - ay)) / (by - ay);
			return (vx < ax + t) ? -1 : 0;
		endfunction

		function coverage_t predict(input tri_item_t it);
			longint x0, y0, x1, y1, x2, y2, px, py, a, tmp;
			longint lo_x, lo_y, hi_x, hi_y, clip_l, clip_t, clip_r, clip_b, e0, e1, e2;
			logic in_box;
			coverage_t r;
			r = '{default: 0};
			x0 = it.v0x;
			y0 = it.v0y;
			x1 = it.v1x;
			y1 = it.v1y;
			x2 = it.v2x;
			y2 = it.v2y;
			px = longint'(it.col) * 16 + 8;
			py = longint'(it.row) * 16 + 8;
			a = signed_area(x0, y0, x1, y1, x2, y2);
			case (cull)
				CULL_KEEP_ALL: r.swapped = (a <= 0);
				CULL_KEEP_CW: begin
					r.swapped = 1'b1;
					r.culled = (a >= 0);
				end
				default: r.culled = (a <= 0);
			endcase
			if (r.swapped) begin
				tmp = x1;
				x1 = x2;
				x2 = tmp;
				tmp = y1;
				y1 = y2;
				y2 = tmp;
			end
			if (!r.culled) begin
				clip_l = longint'(left) * 16;
				clip_t = longint'(top) * 16;
				clip_r = (longint'(right) + 1) * 16;
				clip_b = (longint'(bottom) + 1) * 16;
				lo_x = (x0 < x1) ? x0 : x1;
				lo_x = (x2 < lo_x) ? x2 : lo_x;
				lo_y = (y0 < y1) ? y0 : y1;
				lo_y = (y2 < lo_y) ? y2 : lo_y;
				hi_x = (x0 > x1) ? x0 : x1;
				hi_x = (x2 > hi_x) ? x2 : hi_x;
				hi_y = (y0 > y1) ? y0 : y1;
				hi_y = (y2 > hi_y) ? y2 : hi_y;
				if (scis == SCIS_INCLUDE) begin
					if (lo_x < clip_l) lo_x = clip_l;
					if (lo_y < clip_t) lo_y = clip_t;
					if (hi_x > clip_r) hi_x = clip_r;
					if (hi_y > clip_b) hi_y = clip_b;
				end
				lo_x = lo_x / 16 * 16;
				lo_y = lo_y / 16 * 16;
				hi_x = (hi_x + 15) / 16 * 16;
				hi_y = (hi_y + 15) / 16 * 16;
				in_box = px >= lo_x + 8 && px < hi_x && py >= lo_y + 8 && py < hi_y;
				if (scis == SCIS_EXCLUDE && px >= clip_l && px < clip_r &&
						py >= clip_t && py < clip_b)
					in_box = 1'b0;
				e0 = fill_bias(x0, y0, x1, y1, x2, y2) + signed_area(x1, y1, x2, y2, px, py);
				e1 = fill_bias(x1, y1, x2, y2, x0, y0) + signed_area(x2, y2, x0, y0, px, py);
				e2 = fill_bias(x2, y2, x0, y0, x1, y1) + signed_area(x0, y0, x1, y1, px, py);
				r.w0 = e0[WeightW-1:0];
				r.w1 = e1[WeightW-1:0];
				r.w2 = e2[WeightW-1:0];
				r.covered = in_box && e0 >= 0 && e1 >= 0 && e2 >= 0;
			end
			return r;
		endfunction

		function void note_item(input tri_item_t it);
			coverage_t want;
			want = predict(it);
			pending_q.push_back(want);
			noted++;
			n_covered += want.covered;
			n_culled += want.culled;
			n_swapped += want.swapped;
		endfunction

		function void compare_field(input string name, input logic signed [WeightW-1:0] want,
				input logic signed [WeightW-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input coverage_t got);
			coverage_t want;
			if (pending_q.size() == 0) begin
				$error("result transfer with no triangle pending");
				errors++;
				return;
			end
			want = pending_q.pop_front();
			checked++;
			compare_field("covered", want.covered, got.covered);
			compare_field("culled", want.culled, got.culled);
			compare_field("weight0", want.w0, got.w0);
			compare_field("weight1", want.w1, got.w1);
			compare_field("weight2", want.w2, got.w2);
			compare_field("swapped", want.swapped, got.swapped);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;
	logic start;
	logic busy;
	logic [CoordW-1:0] vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y;
	logic [PixW-1:0] pixel_col, pixel_row;
	logic done;
	logic covered;
	logic culled;
	logic signed [WeightW-1:0] weight0, weight1, weight2;
	logic swapped;

	coverage_scoreboard sb;
	bit gaps_on;
	int cfg_sets;
	int quiet_cycles;
	tri_item_t taken;
	coverage_t seen;

	triangle_pixel_coverage_test_core uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// monitor: inputs and results are sampled as they stood before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				taken = '{vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
					pixel_col, pixel_row};
				sb.note_item(taken);
			end
			if (done) begin
				seen = '{covered, culled, weight0, weight1, weight2, swapped};
				sb.check_result(seen);
			end
			// watchdog: a missing result leaves the drain loop stuck, which ends here
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic longint rand_upto(input longint hi);
		return longint'($urandom_range(hi));
	endfunction

	function automatic longint clamp_coord(input longint v);
		if (v < 0)
			return 0;
		if (v > CoordMax)
			return CoordMax;
		return v;
	endfunction

	// a column or row around a span of coordinates, one pixel of margin each side
	function automatic logic [PixW-1:0] pixel_near(input longint lo, input longint hi);
		longint c;
		c = lo / 16 - 1 + rand_upto(hi / 16 - lo / 16 + 2);
		if (c < 0) c = 0;
		if (c > PixMax) c = PixMax;
		return PixW'(c);
	endfunction

	function automatic tri_item_t make_item(input int ax, ay, bx, by, qx, qy, c, r);
		tri_item_t it;
		it = '{CoordW'(ax), CoordW'(ay), CoordW'(bx), CoordW'(by), CoordW'(qx), CoordW'(qy),
			PixW'(c), PixW'(r)};
		return it;
	endfunction

	function automatic tri_item_t random_item();
		tri_item_t it;
		longint x[3], y[3];
		longint cx, cy, span, lo, hi, ofs;
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 15) begin
			// whole field range: every bit toggles, coverage is rare here
			it.v0x = CoordW'($urandom);
			it.v0y = CoordW'($urandom);
			it.v1x = CoordW'($urandom);
			it.v1y = CoordW'($urandom);
			it.v2x = CoordW'($urandom);
			it.v2y = CoordW'($urandom);
			it.col = PixW'($urandom);
			it.row = PixW'($urandom);
			return it;
		end
		if (kind < 35) begin
			// vertices on pixel centers or corners, often with flat or vertical edges,
			// so samples land exactly on edges and the fill rule decides
			cx = rand_upto(4000);
			cy = rand_upto(4000);
			ofs = rand_upto(1) * 8;
			for (int i = 0; i < 3; i++) begin
				x[i] = (cx + rand_upto(8)) * 16 + ofs;
				y[i] = (cy + rand_upto(8)) * 16 + ofs;
			end
			if (rand_upto(1)) y[1] = y[0];
			if (rand_upto(1)) x[2] = x[rand_upto(1)];
		end else begin
			if (rand_upto(1)) begin
				// around the scissor box, so the clip and exclude edges get hit
				lo = longint'(sb.left < sb.right ? sb.left : sb.right) * 16 - 800;
				hi = longint'(sb.left < sb.right ? sb.right : sb.left) * 16 + 816;
				cx = lo + rand_upto(hi - lo);
				lo = longint'(sb.top < sb.bottom ? sb.top : sb.bottom) * 16 - 800;
				hi = longint'(sb.top < sb.bottom ? sb.bottom : sb.top) * 16 + 816;
				cy = lo + rand_upto(hi - lo);
			end else begin
				cx = rand_upto(CoordMax);
				cy = rand_upto(CoordMax);
			end
			// mostly small triangles, a few spanning the whole range
			case (rand_upto(9))
				0: span = 32768;
				1, 2: span = 4096;
				3, 4, 5: span = 512;
				default: span = 64;
			endcase
			for (int i = 0; i < 3; i++) begin
				x[i] = cx - span + rand_upto(2 * span);
				y[i] = cy - span + rand_upto(2 * span);
			end
			if (kind < 45) begin
				// zero area: a repeated vertex or three points on one line
				if (rand_upto(1)) begin
					x[2] = x[1];
					y[2] = y[1];
				end else begin
					x[2] = 2 * x[1] - x[0];
					y[2] = 2 * y[1] - y[0];
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			x[i] = clamp_coord(x[i]);
			y[i] = clamp_coord(y[i]);
		end
		it.v0x = CoordW'(x[0]);
		it.v0y = CoordW'(y[0]);
		it.v1x = CoordW'(x[1]);
		it.v1y = CoordW'(y[1]);
		it.v2x = CoordW'(x[2]);
		it.v2y = CoordW'(y[2]);
		// pixel picked in or just around the bounding box
		lo = x[0];
		hi = x[0];
		for (int i = 1; i < 3; i++) begin
			if (x[i] < lo) lo = x[i];
			if (x[i] > hi) hi = x[i];
		end
		it.col = pixel_near(lo, hi);
		lo = y[0];
		hi = y[0];
		for (int i = 1; i < 3; i++) begin
			if (y[i] < lo) lo = y[i];
			if (y[i] > hi) hi = y[i];
		end
		it.row = pixel_near(lo, hi);
		return it;
	endfunction

	// one input transfer, with random idle cycles ahead of it while gaps are on
	task automatic send_item(input tri_item_t it);
		while (gaps_on && $urandom_range(99) < IdlePct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		vert0_x <= it.v0x;
		vert0_y <= it.v0y;
		vert1_x <= it.v1x;
		vert1_y <= it.v1y;
		vert2_x <= it.v2x;
		vert2_y <= it.v2y;
		pixel_col <= it.col;
		pixel_row <= it.row;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// stop sending and wait until every pending result has come back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CfgW-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	// drains the pipeline, then writes all six registers
	task automatic apply_config(input logic [ModeW-1:0] cm, sm,
			input logic [CfgW-1:0] l, t, r, b);
		settle();
		write_reg(REG_CULL_MODE, CfgW'(cm));
		write_reg(REG_SCISSOR_MODE, CfgW'(sm));
		write_reg(REG_SCISSOR_LEFT, l);
		write_reg(REG_SCISSOR_TOP, t);
		write_reg(REG_SCISSOR_RIGHT, r);
		write_reg(REG_SCISSOR_BOTTOM, b);
		cfg_write <= 1'b0;
		cfg_sets++;
	endtask

	task automatic pick_box(output logic [CfgW-1:0] l, t, r, b);
		l = CfgW'($urandom_range(900));
		t = CfgW'($urandom_range(900));
		r = l + CfgW'($urandom_range(120));
		b = t + CfgW'($urandom_range(120));
	endtask

	// the same wedge both ways round under one cull mode
	task automatic wedge_under_cull(input logic [ModeW-1:0] cm, input tri_item_t ccw, cw);
		apply_config(cm, SCIS_OFF, '0, '0, ScisLast, ScisLast);
		send_item(ccw);
		send_item(cw);
	endtask

	initial begin
		tri_item_t wedge_ccw, wedge_cw;
		logic [CfgW-1:0] bl, bt, br, bb;
		sb = new();
		gaps_on = 1'b1;
		cfg_sets = 0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_CULL_MODE;
		cfg_data <= '0;
		start <= 1'b0;
		vert0_x <= '0;
		vert0_y <= '0;
		vert1_x <= '0;
		vert1_y <= '0;
		vert2_x <= '0;
		vert2_y <= '0;
		pixel_col <= '0;
		pixel_row <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values: field extremes, both windings, zero area
		send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(65535, 65535, 65535, 65535, 65535, 65535, 4095, 4095));
		send_item(make_item(0, 0, 65535, 0, 0, 65535, 1000, 1000));
		send_item(make_item(0, 0, 0, 65535, 65535, 0, 1000, 1000));
		send_item(make_item(0, 0, 65535, 0, 0, 65535, 4095, 4095));
		send_item(make_item(0, 0, 65535, 0, 0, 65535, 0, 0));
		// samples on a vertex, the flat top edge, the vertical left edge and the diagonal
		send_item(make_item(8, 8, 72, 8, 8, 72, 0, 0));
		send_item(make_item(8, 8, 72, 8, 8, 72, 2, 0));
		send_item(make_item(8, 8, 72, 8, 8, 72, 0, 2));
		send_item(make_item(8, 8, 72, 8, 8, 72, 2, 2));
		send_item(make_item(8, 8, 72, 8, 8, 72, 1, 1));
		// samples on a vertical right edge and a flat bottom edge
		send_item(make_item(72, 8, 72, 72, 8, 72, 4, 2));
		send_item(make_item(72, 8, 72, 72, 8, 72, 2, 4));
		send_item(make_item(16, 16, 32, 32, 48, 48, 2, 2));

		// keep cw, keep ccw and code three, each on one wedge in both windings
		wedge_ccw = make_item(8, 8, 168, 8, 8, 168, 2, 2);
		wedge_cw = make_item(8, 8, 8, 168, 168, 8, 2, 2);
		wedge_under_cull(CULL_KEEP_CW, wedge_ccw, wedge_cw);
		wedge_under_cull(CULL_KEEP_CCW, wedge_ccw, wedge_cw);
		wedge_under_cull(CULL_MODE_THREE, wedge_ccw, wedge_cw);
		// include box with left past right: empty box
		apply_config(CULL_KEEP_ALL, SCIS_INCLUDE, ScisLast, ScisLast, '0, '0);
		send_item(wedge_ccw);
		// exclude box over the wedge corner: one pixel inside it, one beside it
		apply_config(CULL_KEEP_ALL, SCIS_EXCLUDE, '0, '0, 10'd5, 10'd5);
		send_item(wedge_ccw);
		send_item(make_item(8, 8, 168, 8, 8, 168, 7, 1));
		// scissor code three ignores the same box
		apply_config(CULL_KEEP_ALL, SCIS_MODE_THREE, '0, '0, 10'd5, 10'd5);
		send_item(wedge_ccw);

		// random phases, each after a full drain so the registers change while idle
		apply_config(CULL_KEEP_ALL, SCIS_OFF, '0, '0, ScisLast, ScisLast);
		repeat (60) send_item(random_item());
		apply_config(CULL_KEEP_CW, SCIS_INCLUDE, '0, '0, ScisLast, ScisLast);
		repeat (50) send_item(random_item());
		pick_box(bl, bt, br, bb);
		apply_config(CULL_KEEP_CCW, SCIS_INCLUDE, bl, bt, br, bb);
		repeat (55) send_item(random_item());
		// back-to-back transfers with no idle cycle at all
		pick_box(bl, bt, br, bb);
		apply_config(CULL_KEEP_ALL, SCIS_EXCLUDE, bl, bt, br, bb);
		gaps_on = 1'b0;
		repeat (60) send_item(random_item());
		gaps_on = 1'b1;
		apply_config(CULL_MODE_THREE, SCIS_MODE_THREE, ScisLast, ScisLast, '0, '0);
		repeat (45) send_item(random_item());
		pick_box(bl, bt, br, bb);
		apply_config(CULL_KEEP_ALL, SCIS_INCLUDE, bl, bt, br, bb);
		repeat (55) send_item(random_item());
		pick_box(bl, bt, br, bb);
		apply_config(CULL_KEEP_CW, SCIS_EXCLUDE, bl, bt, br, bb);
		repeat (50) send_item(random_item());
		// exclude only the last pixel of the scissor range
		apply_config(CULL_KEEP_ALL, SCIS_EXCLUDE, ScisLast, ScisLast, ScisLast, ScisLast);
		repeat (35) send_item(random_item());
		apply_config(CULL_KEEP_ALL, SCIS_OFF, '0, '0, ScisLast, ScisLast);
		repeat (40) send_item(random_item());
		settle();

		$display("coverage run: %0d triangles, %0d results checked, %0d covered, %0d culled, %0d swapped",
			sb.noted, sb.checked, sb.n_covered, sb.n_culled, sb.n_swapped);
		$display("register sets applied: %0d, over all cull and scissor codes and box extremes",
			cfg_sets);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
design/tpct_pkg.sv
design/triangle_pixel_coverage_test_core.sv
bench/triangle_pixel_coverage_test_core_test.sv
